/* sv/vhh_pkg.sv */
package vhh_pkg;

   // Command codes carried on req_tuser.
   localparam logic [3:0] CMD_SET_PORTS   = 4'd0;
   localparam logic [3:0] CMD_OPEN_PORTS  = 4'd1;
   localparam logic [3:0] CMD_CLOSE_PORTS = 4'd2;
   localparam logic [3:0] CMD_OPEN_INLET  = 4'd3;
   localparam logic [3:0] CMD_CLOSE_INLET = 4'd4;
   localparam logic [3:0] CMD_OPEN_OUTLET = 4'd5;
   localparam logic [3:0] CMD_CLOSE_OUTLET= 4'd6;
   localparam logic [3:0] CMD_PUMP_START  = 4'd7;
   localparam logic [3:0] CMD_PUMP_STOP   = 4'd8;
   localparam logic [3:0] CMD_OPTIMIZE    = 4'd9;
   localparam logic [3:0] CMD_TICK        = 4'd10;

   localparam logic [1:0] PUMP_ONE = 2'd1;
   localparam logic [1:0] PUMP_TWO = 2'd2;

   localparam int         OUT_PORTS   = 5;
   localparam logic [7:0] FULL_LEVEL  = 8'd255;
   localparam int         ELAPSED_W   = 17;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'd65536;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 88;

   typedef struct packed {
      logic [15:0] threshold_ms;
      logic [7:0]  hold_level;
      logic [7:0]  pump_level;
      logic [1:0]  pump_number;
      logic [4:0]  port_mask;
      logic [3:0]  command;
   } item_type;

   typedef struct packed {
      logic [8:0] status_word;
      logic [7:0] pump2_drive;
      logic [7:0] pump1_drive;
      logic [7:0] outlet_drive;
      logic [7:0] inlet_drive;
      logic [7:0] port5_drive;
      logic [7:0] port4_drive;
      logic [7:0] port3_drive;
      logic [7:0] port2_drive;
      logic [7:0] port1_drive;
   } result_type;

endpackage

/* sv/valve_hit_and_hold_driver_unit.sv */
// Hit-and-hold driver for port, inlet and outlet solenoid valves and two pumps.
// Commands arrive as transactions on the req_ stream: req_tuser carries the
// command code, req_tdata its arguments. Every accepted transaction produces
// exactly one rsp_ transaction with all drive levels and the status word,
// taken after the command has been applied.
// The input register takes a transaction when it is accepted; when the result
// register is free or being read, it passes through the valve update into the
// result register, which drives rsp_tvalid and rsp_tdata. Throughput is one
// transaction per cycle while rsp_tready stays high; the valve update is a
// single pass of shallow logic over all valves in parallel.
// After reset every valve is closed with level zero, elapsed counters are
// zero, both pumps are stopped and the last hold level is zero. The block is
// ready for a transaction in the first cycle after reset.
// When rsp_tready is low, the result register holds its transaction and the
// input register can still take one more; req_tready drops only when both
// are full. No transaction is lost or repeated under any stall pattern.
module valve_hit_and_hold_driver_unit #(
   parameter int NUM_PORTS = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // port_mask[4:0], pump_number[6:5], pump_level[14:7], hold_level[22:15],
   // threshold_ms[38:23], zero fill [39]
   input  logic [vhh_pkg::REQ_DATA_W-1:0] req_tdata,
   // command[3:0]
   input  logic [vhh_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // port1..port5_drive[39:0], inlet_drive[47:40], outlet_drive[55:48],
   // pump1_drive[63:56], pump2_drive[71:64], status_word[80:72], zero fill
   output logic [vhh_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import vhh_pkg::*;

   logic       item_valid;
   item_type   item;
   result_type result;
   logic       advance;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   assign advance = item_valid && (!rsp_valid_ff || rsp_tready);

   vhh_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   vhh_core #(
      .NUM_PORTS (NUM_PORTS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .result (result)
   );

   always_comb begin
      rsp_data_in  = advance ? result : rsp_data_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, rsp_data_ff};
endmodule

/* sv/vhh_in_stage.sv */
module vhh_in_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [vhh_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [vhh_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                        advance,
   output logic                        item_valid,
   output vhh_pkg::item_type           item
);
   import vhh_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   // The register may refill in the same cycle that its item moves on.
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      item_in = item_ff;
      if (take) begin
         item_in.command      = req_tuser[3:0];
         item_in.port_mask    = req_tdata[4:0];
         item_in.pump_number  = req_tdata[6:5];
         item_in.pump_level   = req_tdata[14:7];
         item_in.hold_level   = req_tdata[22:15];
         item_in.threshold_ms = req_tdata[38:23];
      end
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

/* sv/vhh_core.sv */
module vhh_core #(
   parameter int NUM_PORTS = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  vhh_pkg::item_type    item,
   output vhh_pkg::result_type  result
);
   import vhh_pkg::*;

   localparam int NUM_VALVES = NUM_PORTS + 2;
   localparam int INLET      = NUM_PORTS;
   localparam int OUTLET     = NUM_PORTS + 1;
   localparam int MASK_PORTS = (NUM_PORTS < OUT_PORTS) ? NUM_PORTS : OUT_PORTS;

   logic [7:0]           level_ff   [NUM_VALVES];
   logic [7:0]           level_in   [NUM_VALVES];
   logic [NUM_VALVES-1:0] open_ff, open_in, held_ff, held_in;
   logic [ELAPSED_W-1:0] elapsed_ff [NUM_VALVES];
   logic [ELAPSED_W-1:0] elapsed_in [NUM_VALVES];
   logic [7:0]           pump_ff    [2];
   logic [7:0]           pump_in    [2];
   logic [7:0]           last_hold_ff, last_hold_in;
   logic [NUM_VALVES-1:0] do_open, do_close;
   logic [8:0]           status;
   logic [7:0]           port_drive [OUT_PORTS];

   always_comb begin
      do_open  = '0;
      do_close = '0;
      for (int v = 0; v < MASK_PORTS; v++) begin
         case (item.command)
            CMD_SET_PORTS: begin
               do_open[v]  = item.port_mask[v];
               do_close[v] = !item.port_mask[v];
            end
            CMD_OPEN_PORTS:  do_open[v]  = item.port_mask[v];
            CMD_CLOSE_PORTS: do_close[v] = item.port_mask[v];
            default: ;
         endcase
      end
      case (item.command)
         CMD_OPEN_INLET:   do_open[INLET]   = 1'b1;
         CMD_CLOSE_INLET:  do_close[INLET]  = 1'b1;
         CMD_OPEN_OUTLET:  do_open[OUTLET]  = 1'b1;
         CMD_CLOSE_OUTLET: do_close[OUTLET] = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      last_hold_in = last_hold_ff;
      pump_in      = pump_ff;
      for (int v = 0; v < NUM_VALVES; v++) begin
         level_in[v]   = level_ff[v];
         open_in[v]    = open_ff[v];
         held_in[v]    = held_ff[v];
         elapsed_in[v] = elapsed_ff[v];
         if (do_open[v]) begin
            level_in[v]   = FULL_LEVEL;
            open_in[v]    = 1'b1;
            held_in[v]    = 1'b0;
            elapsed_in[v] = '0;
         end else if (do_close[v]) begin
            level_in[v]   = '0;
            open_in[v]    = 1'b0;
            held_in[v]    = 1'b0;
            elapsed_in[v] = '0;
         end else if (item.command == CMD_OPTIMIZE) begin
            // A held valve follows a changed hold level; an open valve past
            // the threshold drops to the hold level and becomes held.
            if (item.hold_level != last_hold_ff && held_ff[v]) begin
               level_in[v] = item.hold_level;
            end
            if (open_ff[v] && !held_ff[v] &&
                elapsed_ff[v] > {1'b0, item.threshold_ms}) begin
               level_in[v] = item.hold_level;
               held_in[v]  = 1'b1;
            end
         end else if (item.command == CMD_TICK) begin
            if (open_ff[v] && elapsed_ff[v] < ELAPSED_MAX) begin
               elapsed_in[v] = elapsed_ff[v] + ELAPSED_W'(1);
            end
         end
      end
      case (item.command)
         CMD_PUMP_START: begin
            if (item.pump_number == PUMP_ONE) pump_in[0] = item.pump_level;
            if (item.pump_number == PUMP_TWO) pump_in[1] = item.pump_level;
         end
         CMD_PUMP_STOP: begin
            if (item.pump_number == PUMP_ONE) pump_in[0] = '0;
            if (item.pump_number == PUMP_TWO) pump_in[1] = '0;
         end
         CMD_OPTIMIZE: last_hold_in = item.hold_level;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= '0;
         held_ff      <= '0;
         last_hold_ff <= '0;
         pump_ff[0]   <= '0;
         pump_ff[1]   <= '0;
         for (int v = 0; v < NUM_VALVES; v++) begin
            level_ff[v]   <= '0;
            elapsed_ff[v] <= '0;
         end
      end else if (fire) begin
         open_ff      <= open_in;
         held_ff      <= held_in;
         last_hold_ff <= last_hold_in;
         pump_ff      <= pump_in;
         for (int v = 0; v < NUM_VALVES; v++) begin
            level_ff[v]   <= level_in[v];
            elapsed_ff[v] <= elapsed_in[v];
         end
      end
   end

   // The result reflects the state after the item.
   always_comb begin
      status = '0;
      for (int k = 0; k < OUT_PORTS; k++) begin
         port_drive[k] = '0;
         if (k < NUM_PORTS) begin
            port_drive[k] = level_in[k];
            status[k]     = open_in[k];
         end
      end
      status[5] = open_in[INLET];
      status[6] = open_in[OUTLET];
      status[7] = pump_in[0] != '0;
      status[8] = pump_in[1] != '0;

      result.port1_drive  = port_drive[0];
      result.port2_drive  = port_drive[1];
      result.port3_drive  = port_drive[2];
      result.port4_drive  = port_drive[3];
      result.port5_drive  = port_drive[4];
      result.inlet_drive  = level_in[INLET];
      result.outlet_drive = level_in[OUTLET];
      result.pump1_drive  = pump_in[0];
      result.pump2_drive  = pump_in[1];
      result.status_word  = status;
   end
endmodule

/* tb/valve_hit_and_hold_driver_unit_tb.sv */
`timescale 1ns / 1ps

module valve_hit_and_hold_driver_unit_tb;
   import vhh_pkg::*;

   localparam int NUM_PORTS  = 5;
   localparam int NUM_VALVES = NUM_PORTS + 2;
   localparam int INLET      = NUM_PORTS;
   localparam int OUTLET     = NUM_PORTS + 1;

   // Codes 11 to 15 are not assigned; they must leave the state untouched.
   localparam logic [3:0] CMD_UNUSED_LO = 4'd11;
   localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
   localparam logic [1:0] PUMP_NONE     = 2'd0;
   localparam logic [1:0] PUMP_BAD      = 2'd3;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int PHASE_ITEMS    = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // port_mask[4:0], pump_number[6:5], pump_level[14:7], hold_level[22:15],
   // threshold_ms[38:23], zero fill [39]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // command[3:0]
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // port1..port5_drive[39:0], inlet_drive[47:40], outlet_drive[55:48],
   // pump1_drive[63:56], pump2_drive[71:64], status_word[80:72], zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;

   valve_hit_and_hold_driver_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   item_type   pending_commands[$];
   result_type drive_levels_due[$];
   item_type   in_flight;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   int responses_checked = 0;
   int cycle_count   = 0;
   int cmd_seen[16];
   logic [7:0] gen_hold = 8'd0;

   // Shadow copy of the valve and pump state.
   logic [7:0]           valve_lvl     [NUM_VALVES];
   bit                   valve_is_open [NUM_VALVES];
   bit                   valve_is_held [NUM_VALVES];
   logic [ELAPSED_W-1:0] valve_ticks   [NUM_VALVES];
   logic [7:0]           pump_lvl      [2];
   logic [7:0]           prev_hold;

   function automatic void clear_valve_state();
      for (int v = 0; v < NUM_VALVES; v++) begin
         valve_lvl[v]     = '0;
         valve_is_open[v] = 1'b0;
         valve_is_held[v] = 1'b0;
         valve_ticks[v]   = '0;
      end
      pump_lvl[0] = '0;
      pump_lvl[1] = '0;
      prev_hold   = '0;
   endfunction

   function automatic void drive_valve(int v, bit opening);
      valve_lvl[v]     = opening ? FULL_LEVEL : 8'd0;
      valve_is_open[v] = opening;
      valve_is_held[v] = 1'b0;
      valve_ticks[v]   = '0;
   endfunction

   function automatic result_type next_drive_levels(item_type it);
      result_type r;
      logic [7:0] port_out [OUT_PORTS];
      logic [8:0] status;
      status = '0;
      case (it.command) inside
         CMD_SET_PORTS, CMD_OPEN_PORTS, CMD_CLOSE_PORTS: begin
            for (int v = 0; v < NUM_PORTS && v < OUT_PORTS; v++) begin
               if (it.command == CMD_SET_PORTS)
                  drive_valve(v, it.port_mask[v]);
               else if (it.port_mask[v])
                  drive_valve(v, it.command == CMD_OPEN_PORTS);
            end
         end
         CMD_OPEN_INLET:   drive_valve(INLET, 1'b1);
         CMD_CLOSE_INLET:  drive_valve(INLET, 1'b0);
         CMD_OPEN_OUTLET:  drive_valve(OUTLET, 1'b1);
         CMD_CLOSE_OUTLET: drive_valve(OUTLET, 1'b0);
         CMD_PUMP_START: begin
            if (it.pump_number == PUMP_ONE || it.pump_number == PUMP_TWO)
               pump_lvl[int'(it.pump_number) - 1] = it.pump_level;
         end
         CMD_PUMP_STOP: begin
            if (it.pump_number == PUMP_ONE || it.pump_number == PUMP_TWO)
               pump_lvl[int'(it.pump_number) - 1] = '0;
         end
         CMD_OPTIMIZE: begin
            for (int v = 0; v < NUM_VALVES; v++) begin
               // A changed hold level is pushed to valves that are already held.
               if (it.hold_level != prev_hold && valve_is_held[v])
                  valve_lvl[v] = it.hold_level;
               if (valve_is_open[v] && !valve_is_held[v] &&
                   valve_ticks[v] > {1'b0, it.threshold_ms}) begin
                  valve_lvl[v]     = it.hold_level;
                  valve_is_held[v] = 1'b1;
               end
            end
            prev_hold = it.hold_level;
         end
         CMD_TICK: begin
            for (int v = 0; v < NUM_VALVES; v++)
               if (valve_is_open[v] && valve_ticks[v] < ELAPSED_MAX)
                  valve_ticks[v] = valve_ticks[v] + ELAPSED_W'(1);
         end
         default: ;
      endcase
      for (int v = 0; v < OUT_PORTS; v++) begin
         port_out[v] = (v < NUM_PORTS) ? valve_lvl[v] : 8'd0;
         status[v]   = (v < NUM_PORTS) && valve_is_open[v];
      end
      status[5] = valve_is_open[INLET];
      status[6] = valve_is_open[OUTLET];
      status[7] = pump_lvl[0] != 0;
      status[8] = pump_lvl[1] != 0;
      r.port1_drive  = port_out[0];
      r.port2_drive  = port_out[1];
      r.port3_drive  = port_out[2];
      r.port4_drive  = port_out[3];
      r.port5_drive  = port_out[4];
      r.inlet_drive  = valve_lvl[INLET];
      r.outlet_drive = valve_lvl[OUTLET];
      r.pump1_drive  = pump_lvl[0];
      r.pump2_drive  = pump_lvl[1];
      r.status_word  = status;
      return r;
   endfunction

   function automatic void check_field(string name, logic [8:0] want, logic [8:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0d, actual %0d", name, want, seen);
         mismatches++;
      end
   endfunction

   function automatic item_type make_cmd(logic [3:0] cmd, logic [4:0] mask,
                                         logic [1:0] pnum, logic [7:0] plevel,
                                         logic [7:0] hold, logic [15:0] thresh);
      item_type it;
      it.command      = cmd;
      it.port_mask    = mask;
      it.pump_number  = pnum;
      it.pump_level   = plevel;
      it.hold_level   = hold;
      it.threshold_ms = thresh;
      return it;
   endfunction

   // Random arguments; thresholds are mostly small so that valves really get held.
   function automatic item_type random_cmd(logic [3:0] cmd);
      item_type it;
      if ($urandom_range(1) == 0)
         gen_hold = 8'($urandom_range(255));
      it = make_cmd(cmd, 5'($urandom_range(31)), 2'($urandom_range(3)),
                    ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255)),
                    gen_hold,
                    ($urandom_range(7) == 0) ? 16'($urandom_range(65535))
                                             : 16'($urandom_range(24)));
      return it;
   endfunction

   task automatic queue_directed();
      pending_commands.push_back(make_cmd(CMD_SET_PORTS, 5'b10101, PUMP_NONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_OPEN_PORTS, 5'b11111, PUMP_NONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_CLOSE_PORTS, 5'b00001, PUMP_NONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_OPEN_INLET, 5'b00000, PUMP_NONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_OPEN_OUTLET, 5'b00000, PUMP_NONE, 0, 0, 0));
      repeat (3)
         pending_commands.push_back(make_cmd(CMD_TICK, 5'b11111, PUMP_BAD, 255, 255, 16'hFFFF));
      pending_commands.push_back(make_cmd(CMD_OPTIMIZE, 0, PUMP_NONE, 0, 100, 1));
      // Same hold level again: held valves must keep their level.
      pending_commands.push_back(make_cmd(CMD_OPTIMIZE, 0, PUMP_NONE, 0, 100, 0));
      pending_commands.push_back(make_cmd(CMD_OPTIMIZE, 0, PUMP_NONE, 0, 40, 16'hFFFF));
      // Reopening a held valve brings it back to full level.
      pending_commands.push_back(make_cmd(CMD_OPEN_PORTS, 5'b00010, PUMP_NONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_CLOSE_INLET, 0, PUMP_NONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_CLOSE_OUTLET, 0, PUMP_NONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_PUMP_START, 0, PUMP_ONE, 255, 0, 0));
      pending_commands.push_back(make_cmd(CMD_PUMP_START, 0, PUMP_TWO, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_PUMP_START, 0, PUMP_NONE, 77, 0, 0));
      pending_commands.push_back(make_cmd(CMD_PUMP_START, 0, PUMP_BAD, 88, 0, 0));
      pending_commands.push_back(make_cmd(CMD_PUMP_START, 0, PUMP_TWO, 1, 0, 0));
      pending_commands.push_back(make_cmd(CMD_PUMP_STOP, 0, PUMP_BAD, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_PUMP_STOP, 0, PUMP_ONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_UNUSED_LO, 5'b11111, PUMP_TWO, 9, 9, 9));
      pending_commands.push_back(make_cmd(CMD_UNUSED_HI, 5'b11111, PUMP_ONE, 9, 9, 9));
      pending_commands.push_back(make_cmd(CMD_SET_PORTS, 5'b00000, PUMP_NONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_OPTIMIZE, 0, PUMP_NONE, 0, 255, 0));
   endtask

   // Mostly open / tick / optimize sequences, with noise commands in between.
   task automatic queue_random(int count);
      int added;
      int opener;
      added = 0;
      while (added < count) begin
         opener = $urandom_range(4);
         case (opener)
            0: pending_commands.push_back(random_cmd(CMD_SET_PORTS));
            1: pending_commands.push_back(random_cmd(CMD_OPEN_PORTS));
            2: pending_commands.push_back(random_cmd(CMD_OPEN_INLET));
            3: pending_commands.push_back(random_cmd(CMD_OPEN_OUTLET));
            default: pending_commands.push_back(random_cmd(CMD_PUMP_START));
         endcase
         added++;
         repeat ($urandom_range(12)) begin
            pending_commands.push_back(random_cmd(CMD_TICK));
            added++;
         end
         pending_commands.push_back(random_cmd(CMD_OPTIMIZE));
         added++;
         repeat ($urandom_range(3)) begin
            pending_commands.push_back(random_cmd(4'($urandom_range(CMD_UNUSED_HI))));
            added++;
         end
      end
   endtask

   // Holds new commands back until every response is in.
   task automatic drain();
      while (pending_commands.size() != 0 || drive_levels_due.size() != 0 || req_tvalid)
         @(negedge clock);
   endtask

   always @(posedge clock) begin : feed_req
      bit       load;
      item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            drive_levels_due.push_back(next_drive_levels(in_flight));
            cmd_seen[in_flight.command]++;
         end
         if (!req_tvalid || req_tready) begin
            load = 1'b0;
            if (pending_commands.size() != 0 && $urandom_range(99) >= send_idle_pct)
               load = 1'b1;
            if (load) begin
               nxt = pending_commands.pop_front();
               in_flight  <= nxt;
               req_tdata  <= {1'b0, nxt.threshold_ms, nxt.hold_level, nxt.pump_level,
                              nxt.pump_number, nxt.port_mask};
               req_tuser  <= nxt.command;
            end
            req_tvalid <= load;
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      result_type seen;
      result_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[$bits(result_type)-1:0];
         if (drive_levels_due.size() == 0) begin
            $error("response transaction with no command outstanding: %h", seen);
            mismatches++;
         end else begin
            due = drive_levels_due.pop_front();
            check_field("port1_drive", {1'b0, due.port1_drive}, {1'b0, seen.port1_drive});
            check_field("port2_drive", {1'b0, due.port2_drive}, {1'b0, seen.port2_drive});
            check_field("port3_drive", {1'b0, due.port3_drive}, {1'b0, seen.port3_drive});
            check_field("port4_drive", {1'b0, due.port4_drive}, {1'b0, seen.port4_drive});
            check_field("port5_drive", {1'b0, due.port5_drive}, {1'b0, seen.port5_drive});
            check_field("inlet_drive", {1'b0, due.inlet_drive}, {1'b0, seen.inlet_drive});
            check_field("outlet_drive", {1'b0, due.outlet_drive},
                        {1'b0, seen.outlet_drive});
            check_field("pump1_drive", {1'b0, due.pump1_drive}, {1'b0, seen.pump1_drive});
            check_field("pump2_drive", {1'b0, due.pump2_drive}, {1'b0, seen.pump2_drive});
            check_field("status_word", due.status_word, seen.status_word);
         end
         responses_checked++;
      end
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      clear_valve_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 34;
      recv_idle_pct = 82;
      queue_directed();
      queue_random(PHASE_ITEMS);
      drain();

      send_idle_pct = 82;
      recv_idle_pct = 34;
      queue_random(PHASE_ITEMS);
      drain();

      // Full rate: open everything, then random traffic with no stalls.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pending_commands.push_back(make_cmd(CMD_SET_PORTS, 5'b11111, PUMP_NONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_OPEN_INLET, 0, PUMP_NONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_OPEN_OUTLET, 0, PUMP_NONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_OPTIMIZE, 0, PUMP_NONE, 0, 9, 16'hFFFF));
      pending_commands.push_back(make_cmd(CMD_TICK, 0, PUMP_NONE, 0, 0, 0));
      pending_commands.push_back(make_cmd(CMD_OPTIMIZE, 0, PUMP_NONE, 0, 10, 16'hFFFF));
      queue_random(PHASE_ITEMS);
      drain();

      repeat (6) @(negedge clock);
      $display("Checked %0d responses: %0d ticks, %0d optimize, %0d port, %0d pump commands,",
               responses_checked, cmd_seen[CMD_TICK], cmd_seen[CMD_OPTIMIZE],
               cmd_seen[CMD_SET_PORTS] + cmd_seen[CMD_OPEN_PORTS] + cmd_seen[CMD_CLOSE_PORTS],
               cmd_seen[CMD_PUMP_START] + cmd_seen[CMD_PUMP_STOP]);
      $display("  under three stall mixes, with hold-level changes and unused codes.");
      if (mismatches == 0 && drive_levels_due.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* sim.f */
sv/vhh_pkg.sv
sv/vhh_in_stage.sv
sv/vhh_core.sv
sv/valve_hit_and_hold_driver_unit.sv
tb/valve_hit_and_hold_driver_unit_tb.sv
